[rtl/core/length_crc16_frame_receiver_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the length/CRC16 frame receiver
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LENGTH_CRC16_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_CRC16_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define LCRC_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lcrc_pkg.sv]
// ---------------------------------------------------------------------------
// lcrc_pkg
// Types, constants and the bytewise CRC16 (XMODEM) update for the receiver.
// ---------------------------------------------------------------------------
package lcrc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 128;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_IDLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

  localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd250;
  localparam logic [15:0] FLUSH_IDLE_RST    = 16'd50;
  localparam logic [7:0]  MAX_LENGTH_RST    = 8'd128;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PULL = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  localparam logic [7:0]  ACK_CODE = 8'h06;
  localparam logic [7:0]  NAK_CODE = 8'h15;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CW    = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RECV  = 2'd1,
    PH_FLUSH = 2'd2,
    PH_FWD   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/length_crc16_frame_receiver.sv]
// ---------------------------------------------------------------------------
// length_crc16_frame_receiver
// Receives LEN/payload/CRC16 frames bytewise, buffers good frames, replies
// ACK or NAK, and releases payload one byte per pull.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  in_     | in_valid / in_ready  | in_cmd, in_rx_byte
//  out_    | out_valid / out_ready| out_kind, out_byte, out_last
//  cfg_    | cfg_we               | cfg_index, cfg_data
//
//  One item per cycle while in_ready is high; its results enter a 4-entry output queue at the next edge.
//  in_ready drops while that queue holds more than two results (a final pull
//  adds two: the last payload byte and ACK).
//  Payload store is a RAM with registered read data, addressed at the next forwarding index.
//  Reset (rst_n low, synchronous) empties the queue and returns to idle.
// ---------------------------------------------------------------------------
`include "length_crc16_frame_receiver_assert.svh"

module length_crc16_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = lcrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);

  import lcrc_pkg::*;

  localparam int unsigned BC_W = $clog2(MAX_PAYLOAD + 2);
  localparam int unsigned AW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW   = (BC_W > 8) ? BC_W : 8;

  logic [15:0]     frame_timeout_r;
  logic [15:0]     flush_idle_r;
  logic [7:0]      max_length_r;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      frame_length_r, frame_length_nxt;
  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_high_r, crc_high_nxt;
  logic [15:0]     idle_ticks_r, idle_ticks_nxt;

  result_t         oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_ptr_r, oq_rd_ptr_r;
  logic [OQ_CW-1:0] oq_cnt_r;

  logic            in_xfer, out_xfer;
  logic [1:0]      push_n;
  result_t         res0, res1;
  logic            wr_en;
  logic [7:0]      rd_data;
  logic [15:0]     tick_inc;
  logic [CW-1:0]   bc_ext, fl_ext, bc_inc_ext;
  logic            fwd_last;
  logic            len_bad;

  assign in_ready  = (oq_cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (oq_cnt_r != '0);
  assign out_xfer  = out_valid && out_ready;
  assign out_kind  = oq_r[oq_rd_ptr_r].kind;
  assign out_byte  = oq_r[oq_rd_ptr_r].data;
  assign out_last  = oq_r[oq_rd_ptr_r].last;

  assign bc_ext     = CW'(byte_count_r);
  assign fl_ext     = CW'(frame_length_r);
  assign bc_inc_ext = bc_ext + CW'(1);
  assign fwd_last   = (bc_inc_ext >= fl_ext);
  assign tick_inc   = (idle_ticks_r == TICK_MAX) ? idle_ticks_r : idle_ticks_r + 16'd1;
  assign len_bad    = (in_rx_byte == 8'd0) || (in_rx_byte > max_length_r)
                      || (in_rx_byte > 8'(MAX_PAYLOAD));

  lcrc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_count_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (byte_count_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt   = byte_count_r;
    crc_nxt          = crc_r;
    crc_high_nxt     = crc_high_r;
    idle_ticks_nxt   = idle_ticks_r;
    wr_en            = 1'b0;
    push_n           = 2'd0;
    res0             = '{kind: KIND_PAYLOAD, data: rd_data, last: fwd_last};
    res1             = '{kind: KIND_REPLY, data: ACK_CODE, last: 1'b0};
    if (in_xfer) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_cmd == CMD_BYTE) begin
            idle_ticks_nxt = '0;
            if (len_bad) begin
              phase_nxt = PH_FLUSH;
            end else begin
              frame_length_nxt = in_rx_byte;
              byte_count_nxt   = '0;
              crc_nxt          = crc16_byte(CRC_INIT, in_rx_byte);
              phase_nxt        = PH_RECV;
            end
          end
        end
        PH_RECV: begin
          if (in_cmd == CMD_BYTE) begin
            idle_ticks_nxt = '0;
            if (bc_ext < fl_ext) begin
              wr_en          = 1'b1;
              crc_nxt        = crc16_byte(crc_r, in_rx_byte);
              byte_count_nxt = byte_count_r + BC_W'(1);
            end else if (bc_ext == fl_ext) begin
              crc_high_nxt   = in_rx_byte;
              byte_count_nxt = byte_count_r + BC_W'(1);
            end else if ({crc_high_r, in_rx_byte} == crc_r) begin
              byte_count_nxt = '0;
              phase_nxt      = PH_FWD;
            end else begin
              phase_nxt = PH_FLUSH;
            end
          end else if (in_cmd == CMD_TICK) begin
            if (tick_inc > frame_timeout_r) begin
              idle_ticks_nxt = '0;
              phase_nxt      = PH_FLUSH;
            end else begin
              idle_ticks_nxt = tick_inc;
            end
          end
        end
        PH_FLUSH: begin
          if (in_cmd == CMD_BYTE) begin
            idle_ticks_nxt = '0;
          end else if (in_cmd == CMD_TICK) begin
            idle_ticks_nxt = tick_inc;
            if (tick_inc >= flush_idle_r) begin
              res0      = '{kind: KIND_REPLY, data: NAK_CODE, last: 1'b0};
              push_n    = 2'd1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_FWD: begin
          if (in_cmd == CMD_PULL) begin
            if (fwd_last) begin
              push_n         = 2'd2;
              byte_count_nxt = '0;
              phase_nxt      = PH_IDLE;
            end else begin
              push_n         = 2'd1;
              byte_count_nxt = byte_count_r + BC_W'(1);
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_timeout_r <= FRAME_TIMEOUT_RST;
      flush_idle_r    <= FLUSH_IDLE_RST;
      max_length_r    <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_TIMEOUT: frame_timeout_r <= cfg_data;
        CFG_FLUSH_IDLE:    flush_idle_r    <= cfg_data;
        CFG_MAX_LENGTH:    max_length_r    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      frame_length_r <= '0;
      byte_count_r   <= '0;
      crc_r          <= '0;
      crc_high_r     <= '0;
      idle_ticks_r   <= '0;
    end else begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      crc_r          <= crc_nxt;
      crc_high_r     <= crc_high_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      oq_r[oq_wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      oq_r[oq_wr_ptr_r + OQ_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      oq_wr_ptr_r <= oq_wr_ptr_r + OQ_AW'(push_n);
      if (out_xfer) begin
        oq_rd_ptr_r <= oq_rd_ptr_r + OQ_AW'(1);
      end
      oq_cnt_r <= oq_cnt_r + OQ_CW'(push_n) - OQ_CW'(out_xfer);
    end
  end

  `LCRC_ASSERT_HOLDS(a_fwd_index, phase_r == PH_FWD, bc_ext < fl_ext, "forward index past frame")
  `LCRC_ASSERT_HOLDS(a_oq_bound, 1'b1, oq_cnt_r <= OQ_CW'(OQ_DEPTH), "output queue overrun")
  `LCRC_ASSERT_HOLDS(a_reply_not_last, out_valid && out_kind == KIND_REPLY, !out_last, "reply marked last")
  `LCRC_ASSERT_NEXT(a_ack_to_idle, push_n == 2'd2, phase_r == PH_IDLE && oq_cnt_r >= OQ_CW'(2), "final pull not closed")

endmodule

[rtl/core/lcrc_ram.sv]
// ---------------------------------------------------------------------------
// lcrc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lcrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
